// ===== hw/rtl/dfc_pkg.sv =====
`default_nettype none
package dfc_pkg;

    localparam int DEF_BUFFER_DEPTH = 4096;
    localparam int DEF_SAMPLE_BITS  = 24;

    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] CFG_DELAY    = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FEEDBACK = 4'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_DAMP     = 4'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_MIX      = 4'd3;

    localparam logic [19:0]        DELAY_RST = 20'd256;
    localparam logic [19:0]        DELAY_MIN = 20'd256;
    localparam logic [16:0]        UNITY     = 17'd65536;
    localparam logic signed [15:0] FB_MAX    = 16'sd32735;
    localparam logic signed [15:0] FB_MIN    = -16'sd32735;

    // multiplier coefficient width: Q0.16 unity plus sign
    localparam int COEF_W = 18;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_RD0,
        S_RD1,
        S_M_WET,
        S_A_WET,
        S_M_DMP,
        S_A_DMP,
        S_M_FB,
        S_A_FB,
        S_M_DRY,
        S_A_DRY,
        S_M_MIX,
        S_OUT
    } t_state;

endpackage
`default_nettype wire

// ===== hw/rtl/damped_feedback_comb_filter_core.sv =====
// A new input is accepted only in IDLE, so the next sample waits until the
// output of the last one has been loaded. All multiplications run through one
// shared multiplier, each multiply state paired with an add state, and the
// delay RAM has one read port. Reset: synchronous, active low. After reset the
// delay RAM is cleared, one entry per cycle; o_ready stays low until done.
// Config writes are taken at any time (o_cfg_ready is always high).
`default_nettype none
module damped_feedback_comb_filter_core #(
    parameter int BUFFER_DEPTH = dfc_pkg::DEF_BUFFER_DEPTH,
    parameter int SAMPLE_BITS  = dfc_pkg::DEF_SAMPLE_BITS
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_valid,
    output logic                                    o_ready,
    input  wire logic signed [SAMPLE_BITS-1:0]      i_sample_in,
    output logic                                    o_valid,
    input  wire logic                               i_ready,
    output logic      signed [SAMPLE_BITS-1:0]      o_sample_out,
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [dfc_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  wire logic [dfc_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int S    = SAMPLE_BITS;
    localparam int AW   = $clog2(BUFFER_DEPTH);
    localparam int CW   = ((AW + 8) > 20 ? (AW + 8) : 20) + 2;
    localparam int PW   = S + 1 + dfc_pkg::COEF_W;
    localparam int DMAX = (BUFFER_DEPTH - 2) * 256;

    localparam logic signed [CW-1:0] DMAX_C = CW'(DMAX);
    localparam logic signed [CW-1:0] WRAP_C = CW'(BUFFER_DEPTH) << 8;
    localparam logic [AW-1:0]        LAST   = AW'(BUFFER_DEPTH - 1);
    localparam logic signed [S+3:0]  SMAX   = $signed({5'b00000, {(S-1){1'b1}}});
    localparam logic signed [S+3:0]  SMIN   = $signed({5'b11111, {(S-1){1'b0}}});

    function automatic logic signed [S-1:0] sat(input logic signed [S+3:0] v);
        logic signed [S-1:0] res;
        if (v > SMAX) begin
            res = SMAX[S-1:0];
        end else if (v < SMIN) begin
            res = SMIN[S-1:0];
        end else begin
            res = v[S-1:0];
        end
        return res;
    endfunction

    dfc_pkg::t_state r_state, n_state;

    logic [19:0]        r_delay;
    logic signed [15:0] r_fb;
    logic [16:0]        r_damp;
    logic [16:0]        r_mix;

    logic [AW-1:0]        r_clr;
    logic [AW-1:0]        r_wp;
    logic [AW-1:0]        r_i0;
    logic [AW-1:0]        r_i1;
    logic [7:0]           r_f;
    logic signed [S-1:0]  r_x;
    logic signed [S-1:0]  r_s0;
    logic signed [S-1:0]  r_wet;
    logic signed [S-1:0]  r_ds;
    logic signed [PW-1:0] r_acc;
    logic                 r_ov;
    logic signed [S-1:0]  r_out;

    // clamped coefficients
    logic [19:0]                         w_delay;
    logic signed [15:0]                  w_fb;
    logic [16:0]                         w_damp;
    logic [16:0]                         w_mix;
    logic signed [dfc_pkg::COEF_W-1:0]   w_inv_damp;
    logic signed [dfc_pkg::COEF_W-1:0]   w_inv_mix;

    // read position
    logic signed [CW-1:0] w_rp_raw;
    logic signed [CW-1:0] w_rp;
    logic [AW-1:0]        w_i0;

    // shared multiplier
    logic signed [S:0]                   w_a;
    logic signed [dfc_pkg::COEF_W-1:0]   w_b;
    logic signed [PW-1:0]                w_p;

    // RAM
    logic                w_we;
    logic [AW-1:0]       w_waddr;
    logic [S-1:0]        w_wdata;
    logic [AW-1:0]       w_raddr;
    logic [S-1:0]        w_rdata;
    logic signed [S-1:0] w_s1;

    logic signed [S+19:0] w_wet_sum;
    logic signed [S+19:0] w_ds_sum;
    logic signed [S+19:0] w_fb_sum;
    logic signed [S+19:0] w_out_sum;
    logic signed [S+19:0] w_out_shr;

    logic w_in_acc;
    logic w_out_load;

    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_ov;
    assign o_sample_out = r_out;
    assign o_ready     = (r_state == dfc_pkg::S_IDLE);
    assign w_in_acc    = i_valid && o_ready;
    assign w_out_load  = (r_state == dfc_pkg::S_OUT) && (!r_ov || i_ready);

    always_comb begin
        if (r_delay < dfc_pkg::DELAY_MIN) begin
            w_delay = dfc_pkg::DELAY_MIN;
        end else if ($signed(CW'(r_delay)) > DMAX_C) begin
            w_delay = DMAX_C[19:0];
        end else begin
            w_delay = r_delay;
        end
        if (r_fb > dfc_pkg::FB_MAX) begin
            w_fb = dfc_pkg::FB_MAX;
        end else if (r_fb < dfc_pkg::FB_MIN) begin
            w_fb = dfc_pkg::FB_MIN;
        end else begin
            w_fb = r_fb;
        end
        w_damp = (r_damp > dfc_pkg::UNITY) ? dfc_pkg::UNITY : r_damp;
        w_mix  = (r_mix > dfc_pkg::UNITY) ? dfc_pkg::UNITY : r_mix;
    end

    assign w_inv_damp = $signed({1'b0, dfc_pkg::UNITY}) - $signed({1'b0, w_damp});
    assign w_inv_mix  = $signed({1'b0, dfc_pkg::UNITY}) - $signed({1'b0, w_mix});

    // rp = wp*256 - delay, wrapped into [0, DEPTH*256)
    assign w_rp_raw = $signed(CW'({r_wp, 8'b0})) - $signed(CW'(w_delay));
    assign w_rp     = (w_rp_raw < 0) ? (w_rp_raw + WRAP_C) : w_rp_raw;
    assign w_i0     = w_rp[AW+7:8];

    assign w_s1 = $signed(w_rdata);

    always_comb begin
        unique case (r_state)
            dfc_pkg::S_M_WET: begin
                w_a = (S+1)'(w_s1) - (S+1)'(r_s0);
                w_b = $signed(dfc_pkg::COEF_W'(r_f));
            end
            dfc_pkg::S_M_DMP: begin
                w_a = (S+1)'(r_wet) - (S+1)'(r_ds);
                w_b = w_inv_damp;
            end
            dfc_pkg::S_M_FB: begin
                w_a = (S+1)'(r_ds);
                w_b = dfc_pkg::COEF_W'(w_fb);
            end
            dfc_pkg::S_M_DRY: begin
                w_a = (S+1)'(r_x);
                w_b = w_inv_mix;
            end
            default: begin
                w_a = (S+1)'(r_wet);
                w_b = $signed({1'b0, w_mix});
            end
        endcase
    end

    dfc_mul #(
        .A_W (S + 1)
    ) u_mul (
        .i_clk (i_clk),
        .i_a   (w_a),
        .i_b   (w_b),
        .o_p   (w_p)
    );

    assign w_wet_sum = (S+20)'(r_s0) + (S+20)'(w_p >>> 8);
    assign w_ds_sum  = (S+20)'(r_ds) + (S+20)'(w_p >>> 16);
    assign w_fb_sum  = (S+20)'(r_x) + (S+20)'(w_p >>> 15);
    assign w_out_sum = (S+20)'(r_acc) + (S+20)'(w_p);
    assign w_out_shr = w_out_sum >>> 16;

    always_comb begin
        w_raddr = r_i0;
        if (r_state == dfc_pkg::S_RD1) begin
            w_raddr = r_i1;
        end
        w_we    = 1'b0;
        w_waddr = r_wp;
        w_wdata = sat((S+4)'(w_fb_sum));
        if (r_state == dfc_pkg::S_CLEAR) begin
            w_we    = 1'b1;
            w_waddr = r_clr;
            w_wdata = '0;
        end else if (r_state == dfc_pkg::S_A_FB) begin
            w_we = 1'b1;
        end
    end

    dfc_ram #(
        .WIDTH (S),
        .DEPTH (BUFFER_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            dfc_pkg::S_CLEAR: begin
                if (r_clr == LAST) begin
                    n_state = dfc_pkg::S_IDLE;
                end
            end
            dfc_pkg::S_IDLE: begin
                if (w_in_acc) begin
                    n_state = dfc_pkg::S_RD0;
                end
            end
            dfc_pkg::S_RD0:   n_state = dfc_pkg::S_RD1;
            dfc_pkg::S_RD1:   n_state = dfc_pkg::S_M_WET;
            dfc_pkg::S_M_WET: n_state = dfc_pkg::S_A_WET;
            dfc_pkg::S_A_WET: n_state = dfc_pkg::S_M_DMP;
            dfc_pkg::S_M_DMP: n_state = dfc_pkg::S_A_DMP;
            dfc_pkg::S_A_DMP: n_state = dfc_pkg::S_M_FB;
            dfc_pkg::S_M_FB:  n_state = dfc_pkg::S_A_FB;
            dfc_pkg::S_A_FB:  n_state = dfc_pkg::S_M_DRY;
            dfc_pkg::S_M_DRY: n_state = dfc_pkg::S_A_DRY;
            dfc_pkg::S_A_DRY: n_state = dfc_pkg::S_M_MIX;
            dfc_pkg::S_M_MIX: n_state = dfc_pkg::S_OUT;
            dfc_pkg::S_OUT: begin
                if (w_out_load) begin
                    n_state = dfc_pkg::S_IDLE;
                end
            end
            default: n_state = dfc_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dfc_pkg::S_CLEAR;
            r_clr   <= '0;
            r_wp    <= '0;
            r_ds    <= '0;
            r_ov    <= 1'b0;
            r_delay <= dfc_pkg::DELAY_RST;
            r_fb    <= '0;
            r_damp  <= '0;
            r_mix   <= dfc_pkg::UNITY;
        end else begin
            r_state <= n_state;
            if (r_state == dfc_pkg::S_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            if (r_state == dfc_pkg::S_A_DMP) begin
                r_ds <= sat((S+4)'(w_ds_sum));
            end
            if (r_state == dfc_pkg::S_A_FB) begin
                r_wp <= (r_wp == LAST) ? '0 : r_wp + 1'b1;
            end
            if (w_out_load) begin
                r_ov <= 1'b1;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    dfc_pkg::CFG_DELAY:    r_delay <= i_cfg_data[19:0];
                    dfc_pkg::CFG_FEEDBACK: r_fb    <= $signed(i_cfg_data[15:0]);
                    dfc_pkg::CFG_DAMP:     r_damp  <= i_cfg_data[16:0];
                    dfc_pkg::CFG_MIX:      r_mix   <= i_cfg_data[16:0];
                    default: ;
                endcase
            end
        end
    end

    // datapath registers, no reset
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_x  <= i_sample_in;
            r_i0 <= w_i0;
            r_i1 <= (w_i0 == LAST) ? '0 : w_i0 + 1'b1;
            r_f  <= w_rp[7:0];
        end
        if (r_state == dfc_pkg::S_RD1) begin
            r_s0 <= $signed(w_rdata);
        end
        if (r_state == dfc_pkg::S_A_WET) begin
            r_wet <= w_wet_sum[S-1:0];
        end
        if (r_state == dfc_pkg::S_A_DRY) begin
            r_acc <= w_p;
        end
        if (w_out_load) begin
            r_out <= sat(w_out_shr[S+3:0]);
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/dfc_ram.sv =====
`default_nettype none
module dfc_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// ===== hw/rtl/dfc_mul.sv =====
`default_nettype none
module dfc_mul #(
    parameter int A_W = 25
) (
    input  wire logic                                  i_clk,
    input  wire logic signed [A_W-1:0]                 i_a,
    input  wire logic signed [dfc_pkg::COEF_W-1:0]     i_b,
    output logic      signed [A_W+dfc_pkg::COEF_W-1:0] o_p
);

    always_ff @(posedge i_clk) begin
        o_p <= (A_W + dfc_pkg::COEF_W)'(i_a) * (A_W + dfc_pkg::COEF_W)'(i_b);
    end

endmodule
`default_nettype wire
